// File: design/swa_pkg.sv
package swa_pkg;

  localparam int COMM_W     = 10;
  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 32;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = ((COMM_W + WEIGHT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((COMM_W + SUM_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - COMM_W - SUM_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_INS_WB,
    ST_POP_RD,
    ST_POP_WB,
    ST_CLR,
    ST_RESP
  } state_t;

endpackage

// File: design/sparse_weight_accumulator_core.sv
// insert: accept, then read-modify-write of the sum table
// pop: stack read, sum read, zeroing write-back (an empty stack gives a not-found response)
// clear: one touched entry zeroed per cycle, then the stack is emptied
// results land in an output register; new words are taken while it waits
// reset (rst_n low, synchronous) empties the stack, then a zeroing pass over
// every entry of the sum table runs with in_tready low
module sparse_weight_accumulator_core #(
  parameter int COMMUNITIES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [swa_pkg::IN_DATA_W-1:0]  in_tdata,  // community, weight, zero pad
  input  logic [swa_pkg::REQ_W-1:0]      in_tuser,  // req_type
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [swa_pkg::OUT_DATA_W-1:0] out_tdata, // popped_community, popped_sum, zero pad
  output logic                         out_tuser  // found
);

  import swa_pkg::*;

  localparam int AW   = $clog2(COMMUNITIES);
  localparam int CNTW = $clog2(COMMUNITIES + 1);

  state_t state_r, state_nxt;

  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic [CNTW-1:0]     idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [COMM_W-1:0]   comm_r, comm_nxt;
  logic [WEIGHT_W-1:0] weight_r, weight_nxt;
  logic                ok_r, ok_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [COMM_W-1:0]   out_comm_r, out_comm_nxt;
  logic [SUM_W-1:0]    out_sum_r, out_sum_nxt;

  logic                sum_we, sum_re;
  logic [AW-1:0]       sum_waddr, sum_raddr;
  logic [SUM_W-1:0]    sum_wdata, sum_rdata;
  logic                stk_we, stk_re;
  logic [AW-1:0]       stk_waddr, stk_raddr;
  logic [COMM_W-1:0]   stk_rdata;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [COMM_W-1:0]   in_comm;
  logic [WEIGHT_W-1:0] in_weight;
  logic                in_ok;
  logic [SUM_W:0]      add_full;
  logic [SUM_W-1:0]    sum_sat;
  logic                clr_more;

  assign in_comm   = in_tdata[COMM_W-1:0];
  assign in_weight = in_tdata[COMM_W +: WEIGHT_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_ok     = (in_weight != '0) && (32'(in_comm) < 32'(COMMUNITIES));
  assign add_full  = {1'b0, sum_rdata} + (SUM_W + 1)'(weight_r);
  assign sum_sat   = add_full[SUM_W] ? {SUM_W{1'b1}} : add_full[SUM_W-1:0];
  assign clr_more  = (idx_r < cnt_r);

  swa_ram #(.DEPTH(COMMUNITIES), .WIDTH(SUM_W)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  swa_ram #(.DEPTH(COMMUNITIES), .WIDTH(COMM_W)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (comm_r),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (idx_r == CNTW'(COMMUNITIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_INSERT: state_nxt = ST_INS_WB;
            REQ_POP:    state_nxt = (cnt_r != '0) ? ST_POP_RD : ST_RESP;
            REQ_CLEAR:  state_nxt = ST_CLR;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_INS_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP_RD: state_nxt = ST_POP_WB;
      ST_POP_WB: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (!clr_more && !pend_r) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    comm_nxt      = comm_r;
    weight_nxt    = weight_r;
    ok_nxt        = ok_r;
    out_load      = 1'b0;
    out_found_nxt = 1'b0;
    out_comm_nxt  = '0;
    out_sum_nxt   = '0;
    sum_we        = 1'b0;
    sum_waddr     = '0;
    sum_wdata     = '0;
    sum_re        = 1'b0;
    sum_raddr     = '0;
    stk_we        = 1'b0;
    stk_waddr     = AW'(cnt_r);
    stk_re        = 1'b0;
    stk_raddr     = '0;
    case (state_r)
      ST_INIT: begin
        sum_we    = 1'b1;
        sum_waddr = AW'(idx_r);
        idx_nxt   = (idx_r == CNTW'(COMMUNITIES - 1)) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          comm_nxt   = in_comm;
          weight_nxt = in_weight;
          ok_nxt     = in_ok;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          case (in_tuser)
            REQ_INSERT: begin
              sum_re    = in_ok;
              sum_raddr = AW'(in_comm);
            end
            REQ_POP: begin
              stk_re    = (cnt_r != '0);
              stk_raddr = AW'(cnt_r - 1'b1);
            end
            default: ;
          endcase
        end
      end
      ST_INS_WB: begin
        if (out_free) begin
          out_load  = 1'b1;
          sum_we    = ok_r;
          sum_waddr = AW'(comm_r);
          sum_wdata = sum_sat;
          if (ok_r && (sum_rdata == '0) && (cnt_r != CNTW'(COMMUNITIES))) begin
            stk_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_POP_RD: begin
        sum_re    = 1'b1;
        sum_raddr = AW'(stk_rdata);
        cnt_nxt   = cnt_r - 1'b1;
      end
      ST_POP_WB: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_found_nxt = 1'b1;
          out_comm_nxt  = stk_rdata;
          out_sum_nxt   = sum_rdata;
          sum_we        = 1'b1;
          sum_waddr     = AW'(stk_rdata);
        end
      end
      ST_CLR: begin
        // zeroing write uses the stack entry read in the previous cycle
        stk_re    = clr_more;
        stk_raddr = AW'(idx_r);
        pend_nxt  = clr_more;
        if (clr_more) begin
          idx_nxt = idx_r + 1'b1;
        end
        sum_we    = pend_r;
        sum_waddr = AW'(stk_rdata);
        if (!clr_more && !pend_r) begin
          cnt_nxt = '0;
        end
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comm_r   <= comm_nxt;
    weight_r <= weight_nxt;
    ok_r     <= ok_nxt;
    if (out_load) begin
      out_found_r <= out_found_nxt;
      out_comm_r  <= out_comm_nxt;
      out_sum_r   <= out_sum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_sum_r, out_comm_r};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(COMMUNITIES))
    else $error("stack count above table depth");

  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    stk_we |-> (sum_rdata == '0))
    else $error("push of an entry whose sum was nonzero");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_RD) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop did not shrink the stack");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending word");
`endif

endmodule

// File: design/swa_ram.sv
module swa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
